[design/encoder_detent_and_button_debounce_top_macros.svh]
`ifndef ENCODER_DETENT_AND_BUTTON_DEBOUNCE_TOP_MACROS_SVH
`define ENCODER_DETENT_AND_BUTTON_DEBOUNCE_TOP_MACROS_SVH

// check on every edge outside reset
`define ENCDB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every edge, reset included
`define ENCDB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/encdb_pkg.sv]
`timescale 1ns / 1ps
package encdb_pkg;

   localparam int NUM_BUTTONS   = 4;
   localparam int DETENT_SHIFT  = 2;
   localparam int TRANS_PER_DETENT = 1 << DETENT_SHIFT;

   localparam logic        MODE_INIT   = 1'b0;
   localparam logic        MODE_SAMPLE = 1'b1;

   localparam logic        REG_DIR_REVERSED = 1'b0;
   localparam logic        REG_DEBOUNCE_MS  = 1'b1;

   localparam logic [9:0]  DEBOUNCE_RESET = 10'd25;

   localparam logic signed [15:0] PENDING_MAX = 16'sd32767;
   localparam logic signed [15:0] PENDING_MIN = -16'sd32767;
   localparam logic signed [7:0]  REPORT_MAX  = 8'sd127;
   localparam logic signed [7:0]  REPORT_MIN  = -8'sd127;

   typedef enum logic [1:0] {
      EDGE_NONE    = 2'd0,
      EDGE_PRESS   = 2'd1,
      EDGE_RELEASE = 2'd2
   } encdb_edge_type;

   typedef struct packed {
      logic fire;
      logic init;
   } encdb_step_type;

endpackage

[design/encdb_button.sv]
`timescale 1ns / 1ps
module encdb_button (
   input  logic                    clock,
   input  logic                    reset,
   input  encdb_pkg::encdb_step_type step,
   input  logic                    level,
   input  logic [31:0]             now_ms,
   input  logic [9:0]              debounce_ms,
   output encdb_pkg::encdb_edge_type edge_out,
   output logic                    pressed
);
   import encdb_pkg::*;

   logic        raw_ff, raw_in;
   logic        stable_ff, stable_in;
   logic [31:0] change_time_ff, change_time_in;
   logic        cur;
   logic [31:0] elapsed;
   logic        settle;

   assign cur = ~level;

   always_comb begin
      raw_in         = cur;
      change_time_in = (cur != raw_ff) ? now_ms : change_time_ff;
      elapsed        = now_ms - change_time_in;
      settle         = (raw_in != stable_ff) && (elapsed >= {22'd0, debounce_ms});
      stable_in      = stable_ff;
      edge_out       = EDGE_NONE;
      if (step.init) begin
         change_time_in = now_ms;
         stable_in      = cur;
      end else if (settle) begin
         stable_in = raw_in;
         edge_out  = raw_in ? EDGE_PRESS : EDGE_RELEASE;
      end
      pressed = stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff         <= 1'b0;
         stable_ff      <= 1'b0;
         change_time_ff <= 32'd0;
      end else if (step.fire) begin
         raw_ff         <= raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

[design/encdb_detent.sv]
`timescale 1ns / 1ps
module encdb_detent (
   input  logic                      clock,
   input  logic                      reset,
   input  encdb_pkg::encdb_step_type step,
   input  logic                      reanchor,
   input  logic [31:0]               encoder_count,
   input  logic [1:0]                encoder_phase,
   input  logic                      direction_reversed,
   output logic signed [7:0]         encoder_delta
);
   import encdb_pkg::*;

   logic [31:0]        last_count_ff, last_count_in;
   logic [1:0]         rest_phase_ff, rest_phase_in;
   logic signed [2:0]  partial_ff, partial_in;
   logic signed [15:0] pending_ff, pending_in;

   logic signed [31:0] diff;
   logic signed [32:0] acc;
   logic               neg;
   logic               at_rest;
   logic [32:0]        mag;
   logic [32:0]        quot;
   logic [DETENT_SHIFT-1:0] rem;
   logic [15:0]        quot_sat;
   logic signed [17:0] step_detents;
   logic signed [17:0] pend_sum;
   logic signed [15:0] pend_mid;
   logic signed [2:0]  partial_upd;
   logic signed [7:0]  bounded;

   always_comb begin
      diff     = encoder_count - last_count_ff;
      acc      = {diff[31], diff} + {{30{partial_ff[2]}}, partial_ff};
      neg      = acc[32];
      mag      = neg ? 33'(-acc) : 33'(acc);
      at_rest  = (encoder_phase == rest_phase_ff);
      quot     = at_rest ? ((mag + 33'd1) >> DETENT_SHIFT) : (mag >> DETENT_SHIFT);
      rem      = at_rest ? '0 : mag[DETENT_SHIFT-1:0];
      quot_sat = (|quot[32:16]) ? 16'hFFFF : quot[15:0];
      step_detents = neg ? -$signed({2'b00, quot_sat}) : $signed({2'b00, quot_sat});
      pend_sum = {{2{pending_ff[15]}}, pending_ff} + step_detents;
      partial_upd = neg ? -$signed(3'({1'b0, rem})) : $signed(3'({1'b0, rem}));

      if (diff == 32'sd0) begin
         pend_mid   = pending_ff;
         partial_in = partial_ff;
      end else begin
         partial_in = partial_upd;
         if (pend_sum > 18'(PENDING_MAX)) begin
            pend_mid = PENDING_MAX;
         end else if (pend_sum < 18'(PENDING_MIN)) begin
            pend_mid = PENDING_MIN;
         end else begin
            pend_mid = pend_sum[15:0];
         end
      end

      if (pend_mid > 16'(REPORT_MAX)) begin
         bounded = REPORT_MAX;
      end else if (pend_mid < 16'(REPORT_MIN)) begin
         bounded = REPORT_MIN;
      end else begin
         bounded = pend_mid[7:0];
      end

      pending_in    = pend_mid - 16'(bounded);
      last_count_in = encoder_count;
      rest_phase_in = rest_phase_ff;
      encoder_delta = direction_reversed ? -bounded : bounded;

      if (reanchor) begin
         rest_phase_in = encoder_phase;
         partial_in    = 3'sd0;
      end
      if (step.init) begin
         rest_phase_in = encoder_phase;
         partial_in    = 3'sd0;
         pending_in    = 16'sd0;
         encoder_delta = 8'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= 32'd0;
         rest_phase_ff <= 2'd0;
         partial_ff    <= 3'sd0;
         pending_ff    <= 16'sd0;
      end else if (step.fire) begin
         last_count_ff <= last_count_in;
         rest_phase_ff <= rest_phase_in;
         partial_ff    <= partial_in;
         pending_ff    <= pending_in;
      end
   end

endmodule

[design/encoder_detent_and_button_debounce_top.sv]
// Path: an accepted input word is held in the input register, and its result word in the result register.
// Throughput: one word per cycle; the input register holds only while the
// result register is stalled and full.
// Reset: synchronous; clears encoder anchors, button state and both valids,
// and loads direction_reversed 0 and debounce_ms 25.
`timescale 1ns / 1ps
`include "encoder_detent_and_button_debounce_top_macros.svh"
module encoder_detent_and_button_debounce_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [31:0]        req_now_ms,
   input  logic [3:0]         req_raw_levels,
   input  logic [31:0]        req_encoder_count,
   input  logic [1:0]         req_encoder_phase,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [7:0]  rsp_encoder_delta,
   output logic [1:0]         rsp_push_edge,
   output logic               rsp_push_pressed,
   output logic [1:0]         rsp_transport_edge,
   output logic               rsp_transport_pressed,
   output logic [1:0]         rsp_tap_edge,
   output logic               rsp_tap_pressed,
   output logic [1:0]         rsp_back_edge,
   output logic               rsp_back_pressed,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import encdb_pkg::*;

   logic        dir_rev_ff;
   logic [9:0]  debounce_ff;
   logic        csr_write;

   logic        in_valid_ff, in_valid_in;
   logic        in_mode_ff;
   logic [31:0] in_now_ff;
   logic [3:0]  in_levels_ff;
   logic [31:0] in_count_ff;
   logic [1:0]  in_phase_ff;

   logic           out_free;
   logic           advance;
   encdb_step_type step;

   encdb_edge_type     edge_w [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] pressed_w;
   logic signed [7:0]  delta_w;
   logic               reanchor;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]  delta_ff;
   encdb_edge_type     edge_ff [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] pressed_ff;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (paddr[2])
         REG_DIR_REVERSED: prdata = {31'd0, dir_rev_ff};
         REG_DEBOUNCE_MS:  prdata = {22'd0, debounce_ff};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_rev_ff  <= 1'b0;
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_DIR_REVERSED: dir_rev_ff  <= pwdata[0];
            REG_DEBOUNCE_MS:  debounce_ff <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   // input register
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   assign step.fire = advance;
   assign step.init = advance && (in_mode_ff == MODE_INIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff   <= req_mode;
         in_now_ff    <= req_now_ms;
         in_levels_ff <= req_raw_levels;
         in_count_ff  <= req_encoder_count;
         in_phase_ff  <= req_encoder_phase;
      end
   end

   // per-word update
   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_button
      encdb_button u_button (
         .clock       (clock),
         .reset       (reset),
         .step        (step),
         .level       (in_levels_ff[b]),
         .now_ms      (in_now_ff),
         .debounce_ms (debounce_ff),
         .edge_out    (edge_w[b]),
         .pressed     (pressed_w[b])
      );
   end

   assign reanchor = (edge_w[0] == EDGE_RELEASE);

   encdb_detent u_detent (
      .clock              (clock),
      .reset              (reset),
      .step               (step),
      .reanchor           (reanchor),
      .encoder_count      (in_count_ff),
      .encoder_phase      (in_phase_ff),
      .direction_reversed (dir_rev_ff),
      .encoder_delta      (delta_w)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         delta_ff   <= delta_w;
         edge_ff    <= edge_w;
         pressed_ff <= pressed_w;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_encoder_delta     = delta_ff;
   assign rsp_push_edge         = edge_ff[0];
   assign rsp_push_pressed      = pressed_ff[0];
   assign rsp_transport_edge    = edge_ff[1];
   assign rsp_transport_pressed = pressed_ff[1];
   assign rsp_tap_edge          = edge_ff[2];
   assign rsp_tap_pressed       = pressed_ff[2];
   assign rsp_back_edge         = edge_ff[3];
   assign rsp_back_pressed      = pressed_ff[3];

   `ENCDB_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid_ff, "result valid after reset")
   `ENCDB_ASSERT(a_input_holds, in_valid_ff && !out_free |=> in_valid_ff && $stable(in_count_ff), "held word lost")
   `ENCDB_ASSERT(a_delta_range, rsp_valid_ff |-> delta_ff != -8'sd128, "delta out of range")
   `ENCDB_ASSERT(a_press_state, rsp_valid_ff && edge_ff[0] == EDGE_PRESS |-> pressed_ff[0], "press edge without pressed state")
   `ENCDB_ASSERT(a_release_state, rsp_valid_ff && edge_ff[0] == EDGE_RELEASE |-> !pressed_ff[0], "release edge with pressed state")

endmodule
